/* src/gbn_pkg.sv */
// Shared types and constants for the go-back-n sender window.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CMD_DEPTH  = 2;
  localparam int PTR_W      = $clog2(CMD_DEPTH);
  localparam int PADDR_W    = 3;

  // input opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_FINACK = 2'd3;

  // result actions
  localparam logic [1:0] ACT_SEND   = 2'd0;
  localparam logic [1:0] ACT_RESEND = 2'd1;
  localparam logic [1:0] ACT_FIN    = 2'd2;
  localparam logic [1:0] ACT_DONE   = 2'd3;

  // register select, paddr[2]
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [3:0]  WINDOW_RST  = 4'd4;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] packet_count;
    logic [7:0]  ack_seq;
    logic        ack_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] seq_out;
    logic       last;
  } out_item_t;

  // burst of consecutive sequence numbers, all of one action
  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       seq;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_FIN  = 3'b100
  } phase_e;

endpackage

`default_nettype wire

/* src/gbn_cmd_fifo.sv */
// Short command queue between the protocol front end and the result expander.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_cmd_fifo
  import gbn_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  wire  rd_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t               mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;
  logic               do_wr, do_rd;

  assign full_o    = (count_q == (PTR_W + 1)'(CMD_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/gbn_front.sv */
// Protocol front end: takes requests, keeps window/timer state and
// issues at most one burst command per request. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_front
  import gbn_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  in_item_t    in_data_i,
  input  wire  [3:0]  window_i,
  input  wire  [15:0] timeout_i,
  input  wire         cmd_full_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  in_item_t    hold_q;
  logic        hold_valid_q, hold_valid_d;
  phase_e      phase_q, phase_d;
  logic [15:0] acked_q, acked_d;
  logic [15:0] sent_q, sent_d;
  logic [15:0] total_q, total_d;
  logic [15:0] timer_left_q, timer_left_d;
  logic        timer_run_q, timer_run_d;

  logic        accept, process;
  logic [3:0]  w_eff;
  logic [15:0] t_eff;

  // data packets that fit the window, given base, next and total
  function automatic logic [CNT_W-1:0] fill_cnt(input logic [15:0] acked,
                                                 input logic [15:0] sent,
                                                 input logic [15:0] total,
                                                 input logic [3:0]  w);
    logic [15:0] outst, room, remain;
    outst  = sent - acked;
    room   = (outst < {12'd0, w}) ? ({12'd0, w} - outst) : 16'd0;
    remain = total - sent;
    return (remain < room) ? remain[CNT_W-1:0] : room[CNT_W-1:0];
  endfunction

  assign full    = hold_valid_q && cmd_full_i;
  assign accept  = push && !full;
  assign process = hold_valid_q && !cmd_full_i;

  always_comb begin
    if (window_i == 4'd0) begin
      w_eff = 4'd1;
    end else if (window_i > 4'(MAX_WINDOW)) begin
      w_eff = 4'(MAX_WINDOW);
    end else begin
      w_eff = window_i;
    end
    t_eff = (timeout_i == 16'd0) ? 16'd1 : timeout_i;
  end

  always_comb begin
    logic [7:0]       off;
    logic [15:0]      outst, new_acked;
    logic [CNT_W-1:0] cnt;

    off       = hold_q.ack_seq - acked_q[7:0];
    outst     = sent_q - acked_q;
    new_acked = acked_q + {8'd0, off} + 16'd1;
    cnt       = '0;

    phase_d      = phase_q;
    acked_d      = acked_q;
    sent_d       = sent_q;
    total_d      = total_q;
    timer_left_d = timer_left_q;
    timer_run_d  = timer_run_q;
    cmd_o        = '{action: ACT_SEND, seq: acked_q[7:0], count: '0};

    if (process) begin
      unique case (hold_q.op)
        OP_START: begin
          if (phase_q == PH_IDLE) begin
            total_d      = hold_q.packet_count;
            acked_d      = 16'd0;
            sent_d       = 16'd0;
            timer_run_d  = 1'b1;
            timer_left_d = t_eff;
            if (hold_q.packet_count == 16'd0) begin
              phase_d = PH_FIN;
              cmd_o   = '{action: ACT_FIN, seq: 8'd0, count: CNT_W'(1)};
            end else begin
              phase_d = PH_SEND;
              cnt     = fill_cnt(16'd0, 16'd0, hold_q.packet_count, w_eff);
              cmd_o   = '{action: ACT_SEND, seq: 8'd0, count: cnt};
              sent_d  = 16'(cnt);
            end
          end
        end
        OP_ACK: begin
          if (phase_q == PH_SEND) begin
            if (hold_q.ack_ok && ({8'd0, off} < outst)) begin
              acked_d = new_acked;
              if (new_acked == sent_q) begin
                timer_run_d  = 1'b0;
                timer_left_d = 16'd0;
              end else begin
                timer_run_d  = 1'b1;
                timer_left_d = t_eff;
              end
              if (new_acked == total_q) begin
                phase_d      = PH_FIN;
                timer_run_d  = 1'b1;
                timer_left_d = t_eff;
                cmd_o = '{action: ACT_FIN, seq: new_acked[7:0], count: CNT_W'(1)};
              end else begin
                cnt = fill_cnt(new_acked, sent_q, total_q, w_eff);
                // timer restarts when the window was drained
                if (cnt != '0 && new_acked == sent_q) begin
                  timer_run_d  = 1'b1;
                  timer_left_d = t_eff;
                end
                cmd_o  = '{action: ACT_SEND, seq: sent_q[7:0], count: cnt};
                sent_d = sent_q + 16'(cnt);
              end
            end
          end else if (phase_q == PH_FIN) begin
            timer_run_d  = 1'b1;
            timer_left_d = t_eff;
            cmd_o = '{action: ACT_FIN, seq: acked_q[7:0], count: CNT_W'(1)};
          end
        end
        OP_TICK: begin
          if (timer_run_q && phase_q != PH_IDLE) begin
            if (timer_left_q <= 16'd1) begin
              timer_left_d = t_eff;
              if (phase_q == PH_SEND) begin
                cnt = (outst > 16'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : outst[CNT_W-1:0];
                cmd_o = '{action: ACT_RESEND, seq: acked_q[7:0], count: cnt};
              end else begin
                cmd_o = '{action: ACT_FIN, seq: acked_q[7:0], count: CNT_W'(1)};
              end
            end else begin
              timer_left_d = timer_left_q - 16'd1;
            end
          end
        end
        OP_FINACK: begin
          if (phase_q == PH_FIN) begin
            if (hold_q.ack_ok) begin
              phase_d      = PH_IDLE;
              timer_run_d  = 1'b0;
              timer_left_d = 16'd0;
              cmd_o = '{action: ACT_DONE, seq: 8'd0, count: CNT_W'(1)};
            end else begin
              timer_run_d  = 1'b1;
              timer_left_d = t_eff;
              cmd_o = '{action: ACT_FIN, seq: acked_q[7:0], count: CNT_W'(1)};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_push_o   = process && (cmd_o.count != '0);
  assign hold_valid_d = accept ? 1'b1 : (process ? 1'b0 : hold_valid_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      phase_q      <= PH_IDLE;
      acked_q      <= '0;
      sent_q       <= '0;
      total_q      <= '0;
      timer_left_q <= '0;
      timer_run_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      phase_q      <= phase_d;
      acked_q      <= acked_d;
      sent_q       <= sent_d;
      total_q      <= total_d;
      timer_left_q <= timer_left_d;
      timer_run_q  <= timer_run_d;
    end
  end

endmodule

`default_nettype wire

/* src/gbn_back.sv */
// Result expander: turns each burst command into one result per cycle
// into the output register while that register is empty or popped. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_back
  import gbn_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty,
  input  wire        pop,
  output out_item_t  out_data_o
);

  logic             busy_q, busy_d;
  logic [1:0]       act_q, act_d;
  logic [7:0]       seq_q, seq_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             advance;

  assign advance    = !out_valid_q || pop;
  assign cmd_pop_o  = !busy_q && !cmd_empty_i;
  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    busy_d      = busy_q;
    act_d       = act_q;
    seq_d       = seq_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (advance) begin
      out_valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      busy_d = 1'b1;
      act_d  = cmd_i.action;
      seq_d  = cmd_i.seq;
      left_d = cmd_i.count;
    end else if (busy_q && advance) begin
      out_valid_d = 1'b1;
      out_d       = '{action: act_q, seq_out: seq_q, last: (left_q == CNT_W'(1))};
      seq_d       = seq_q + 8'd1;
      left_d      = left_q - CNT_W'(1);
      busy_d      = (left_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    seq_q <= seq_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* src/go_back_n_sender_window.sv */
// Go-back-n sender window: APB registers, front end, command queue, expander.
// A request passes the hold register, command queue and expander burst registers
// before its first result reaches the output register. Throughput: the front end
// takes one request a cycle while the command queue has room; the expander loads one
// burst at a time and gives one result per cycle of it while the output is popped.
// Reset clears all control state; the window register reads 4, the timeout 1000.
// Depends on gbn_pkg, gbn_front, gbn_cmd_fifo, gbn_back.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push,
  output logic              full,
  input  in_item_t          in_data_i,
  output logic              empty,
  input  wire               pop,
  output out_item_t         out_data_o,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [PADDR_W-1:0] paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [3:0]  window_q;
  logic [15:0] timeout_q;
  logic        cfg_wr;
  logic        cmd_full, cmd_push, cmd_pop, cmd_empty;
  cmd_t        cmd_wr, cmd_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : {28'd0, window_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW) begin
        window_q <= pwdata[3:0];
      end else begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  gbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .window_i   (window_q),
    .timeout_i  (timeout_q),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  gbn_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_wr),
    .full_o    (cmd_full),
    .rd_i      (cmd_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (cmd_empty)
  );

  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for go_back_n_sender_window: directed table, then random transfers.
// Expected commands come from an in-file model of the sender window state.
// Depends on gbn_pkg and the go_back_n_sender_window RTL.
`timescale 1ns / 1ps

module testbench;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_TARGET   = 300;
  localparam int RAND_SLACK    = 40;
  localparam int SETTLE_CYCLES = 16;
  localparam int NUM_DIR       = 21;

  localparam logic [PADDR_W-1:0] WINDOW_ADDR  = {REG_WINDOW, 2'b00};
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam out_item_t NO_CMD = '0;

  // n_fixed < 0: expectation from the model; 0: no command; above 0: the one typed-in command
  typedef struct {
    in_item_t  req;
    int        n_fixed;
    out_item_t fixed;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_item_t           req_bus;
  logic               empty;
  logic               pop;
  out_item_t          cmd_bus;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // sender window model
  phase_e      m_phase;
  logic [15:0] m_base;
  logic [15:0] m_next;
  logic [15:0] m_total;
  logic [15:0] m_timer;
  logic        m_timer_on;
  logic [3:0]  m_window;
  logic [15:0] m_timeout;

  out_item_t step_cmds[$];
  out_item_t expected_cmds[$];

  int mismatch_cnt = 0;
  int rand_cnt     = 0;
  int cycle_cnt    = 0;
  bit send_eager   = 1'b0;
  bit take_eager   = 1'b0;

  dir_row_t dir_rows [NUM_DIR] = '{
    // idle: everything but start is dropped
    '{'{OP_ACK,    16'd0,     8'd0,   1'b1}, 0, NO_CMD},
    '{'{OP_TICK,   16'd0,     8'd0,   1'b0}, 0, NO_CMD},
    '{'{OP_FINACK, 16'd0,     8'd0,   1'b1}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd255, 1'b0}, 0, NO_CMD},
    // empty transfer goes straight to FIN
    '{'{OP_START,  16'd0,     8'd0,   1'b1}, 1, '{ACT_FIN, 8'd0, 1'b1}},
    '{'{OP_START,  16'd5,     8'd0,   1'b0}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd7,   1'b0}, 1, '{ACT_FIN, 8'd0, 1'b1}},
    '{'{OP_FINACK, 16'd0,     8'd0,   1'b0}, 1, '{ACT_FIN, 8'd0, 1'b1}},
    '{'{OP_TICK,   16'd0,     8'd0,   1'b0}, 0, NO_CMD},
    '{'{OP_FINACK, 16'd0,     8'd0,   1'b1}, 1, '{ACT_DONE, 8'd0, 1'b1}},
    // ten packets, default window
    '{'{OP_START,  16'd10,    8'd0,   1'b0}, -1, NO_CMD},
    '{'{OP_FINACK, 16'd0,     8'd0,   1'b1}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd1,   1'b0}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd255, 1'b1}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd4,   1'b1}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd1,   1'b1}, -1, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd1,   1'b1}, 0, NO_CMD},
    '{'{OP_START,  16'd3,     8'd0,   1'b1}, 0, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd5,   1'b1}, -1, NO_CMD},
    '{'{OP_ACK,    16'd0,     8'd9,   1'b1}, 1, '{ACT_FIN, 8'd10, 1'b1}},
    '{'{OP_FINACK, 16'd0,     8'd0,   1'b1}, 1, '{ACT_DONE, 8'd0, 1'b1}}
  };

  go_back_n_sender_window DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (req_bus),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (cmd_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] window_eff();
    logic [15:0] w;
    w = 16'(m_window);
    if (w == 16'd0) w = 16'd1;
    else if (w > 16'(MAX_WINDOW)) w = 16'(MAX_WINDOW);
    return w;
  endfunction

  function automatic logic [15:0] timeout_eff();
    return (m_timeout == 16'd0) ? 16'd1 : m_timeout;
  endfunction

  function automatic void emit_cmd(logic [1:0] act, logic [15:0] seq);
    out_item_t c;
    c.action  = act;
    c.seq_out = seq[7:0];
    c.last    = 1'b0;
    step_cmds.push_back(c);
  endfunction

  function automatic void arm_timer();
    m_timer_on = 1'b1;
    m_timer    = timeout_eff();
  endfunction

  function automatic void enter_fin();
    m_phase = PH_FIN;
    arm_timer();
    emit_cmd(ACT_FIN, m_base);
  endfunction

  function automatic void fill_window();
    while (16'(m_next - m_base) < window_eff() && m_next < m_total &&
           step_cmds.size() < MAX_WINDOW) begin
      if (m_next == m_base) arm_timer();
      emit_cmd(ACT_SEND, m_next);
      m_next = m_next + 16'd1;
    end
  endfunction

  // Advances the model by one request; step_cmds gets its commands.
  function automatic void model_step(in_item_t req);
    logic [7:0]  off;
    logic [15:0] pending;
    logic [15:0] s;
    step_cmds.delete();
    case (req.op)
      OP_START: begin
        if (m_phase == PH_IDLE) begin
          m_total    = req.packet_count;
          m_base     = 16'd0;
          m_next     = 16'd0;
          m_timer_on = 1'b0;
          m_timer    = 16'd0;
          if (m_total == 16'd0) begin
            enter_fin();
          end else begin
            m_phase = PH_SEND;
            fill_window();
          end
        end
      end
      OP_ACK: begin
        if (m_phase == PH_SEND) begin
          if (req.ack_ok) begin
            off     = req.ack_seq - m_base[7:0];
            pending = m_next - m_base;
            // only numbers inside the outstanding window move the base
            if (16'(off) < pending) begin
              m_base = m_base + 16'(off) + 16'd1;
              if (m_base == m_next) begin
                m_timer_on = 1'b0;
                m_timer    = 16'd0;
              end else begin
                arm_timer();
              end
              if (m_base == m_total) enter_fin();
              else fill_window();
            end
          end
        end else if (m_phase == PH_FIN) begin
          enter_fin();
        end
      end
      OP_TICK: begin
        if (m_timer_on && m_phase != PH_IDLE) begin
          if (m_timer <= 16'd1) begin
            m_timer = timeout_eff();
            if (m_phase == PH_SEND) begin
              s = m_base;
              while (s != m_next && step_cmds.size() < MAX_WINDOW) begin
                emit_cmd(ACT_RESEND, s);
                s = s + 16'd1;
              end
            end else begin
              emit_cmd(ACT_FIN, m_base);
            end
          end else begin
            m_timer = m_timer - 16'd1;
          end
        end
      end
      default: begin
        if (m_phase == PH_FIN) begin
          if (req.ack_ok) begin
            m_phase    = PH_IDLE;
            m_timer_on = 1'b0;
            m_timer    = 16'd0;
            emit_cmd(ACT_DONE, 16'd0);
          end else begin
            enter_fin();
          end
        end
      end
    endcase
    if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
  endfunction

  task automatic issue_request(input in_item_t req, input int n_fixed,
                               input out_item_t fixed);
    int gap;
    if ($urandom_range(0, 29) == 0) send_eager = !send_eager;
    gap = send_eager ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push    <= 1'b1;
    req_bus <= req;
    do @(posedge clk_i); while (full);
    model_step(req);
    if (n_fixed < 0) begin
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    end else if (n_fixed > 0) begin
      expected_cmds.push_back(fixed);
    end
  endtask

  // drop push, wait for all commands, then let in-flight requests finish
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [PADDR_W-1:0] addr, input logic [15:0] want);
    logic [31:0] rd;
    logic [15:0] got;
    apb_access(1'b0, addr, 32'd0, rd);
    got = (addr == WINDOW_ADDR) ? {12'd0, rd[3:0]} : rd[15:0];
    if (got != want) begin
      mismatch_cnt++;
      $display("%0t: register at %0d expected %0d, got %0d", $time, addr, want, got);
    end
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, addr, val, rd);
    if (addr == WINDOW_ADDR) begin
      m_window = val[3:0];
      check_reg(addr, 16'(m_window));
    end else begin
      m_timeout = val[15:0];
      check_reg(addr, m_timeout);
    end
  endtask

  // result side: random pop stalls, compare against the oldest expectation
  initial begin
    out_item_t want;
    out_item_t got;
    int        stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) take_eager = !take_eager;
      stall = take_eager ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = cmd_bus;
      if (expected_cmds.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: expected no result, got action=%0d seq_out=%0d last=%0d",
                 $time, got.action, got.seq_out, got.last);
      end else begin
        want = expected_cmds.pop_front();
        if (got.action != want.action) begin
          mismatch_cnt++;
          $display("%0t: action expected %0d, got %0d", $time, want.action, got.action);
        end
        if (got.seq_out != want.seq_out) begin
          mismatch_cnt++;
          $display("%0t: seq_out expected %0d, got %0d", $time, want.seq_out, got.seq_out);
        end
        if (got.last != want.last) begin
          mismatch_cnt++;
          $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    in_item_t    req;
    int          roll;
    int          n_pend;
    int          phase_items;
    bit          started;
    logic [3:0]  win_val;
    logic [15:0] tmo_val;

    rst_ni     = 1'b0;
    push       = 1'b0;
    req_bus    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    m_phase    = PH_IDLE;
    m_base     = 16'd0;
    m_next     = 16'd0;
    m_total    = 16'd0;
    m_timer    = 16'd0;
    m_timer_on = 1'b0;
    m_window   = 4'd4;
    m_timeout  = 16'd1000;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reg(WINDOW_ADDR, 16'd4);
    check_reg(TIMEOUT_ADDR, 16'd1000);

    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].n_fixed, dir_rows[i].fixed);

    // random transfers, one per phase, new register settings each time
    while (rand_cnt < RAND_TARGET) begin
      settle();
      case ($urandom_range(0, 5))
        0:       win_val = 4'd0;
        1:       win_val = 4'd15;
        2:       win_val = 4'd1;
        3:       win_val = 4'd8;
        default: win_val = 4'($urandom_range(2, 14));
      endcase
      case ($urandom_range(0, 9))
        0:       tmo_val = 16'd0;
        1:       tmo_val = 16'hFFFF;
        2:       tmo_val = 16'd1;
        default: tmo_val = 16'($urandom_range(2, 8));
      endcase
      write_reg(WINDOW_ADDR, {28'd0, win_val});
      write_reg(TIMEOUT_ADDR, {16'd0, tmo_val});

      started     = 1'b0;
      phase_items = 0;
      while (!(started && m_phase == PH_IDLE) && phase_items < 3000 &&
             rand_cnt < RAND_TARGET + RAND_SLACK) begin
        // noise by default, overridden by a well-formed request most of the time
        req.op           = 2'($urandom);
        req.packet_count = 16'($urandom);
        req.ack_seq      = 8'($urandom);
        req.ack_ok       = 1'($urandom);
        roll   = $urandom_range(0, 99);
        n_pend = int'(16'(m_next - m_base));
        case (m_phase)
          PH_IDLE: begin
            if (roll < 92) begin
              req.op = OP_START;
              if (roll < 8) req.packet_count = 16'd0;
              else if (roll < 16 && window_eff() >= 16'd4)
                req.packet_count = 16'($urandom_range(250, 300));
              else req.packet_count = 16'($urandom_range(1, 24));
            end
          end
          PH_SEND: begin
            if (roll < 60 && n_pend > 0) begin
              req.op      = OP_ACK;
              req.ack_ok  = 1'b1;
              req.ack_seq = m_base[7:0] + 8'($urandom_range(0, n_pend - 1));
            end else if (roll < 72) begin
              req.op = OP_ACK;
            end else if (roll < 90) begin
              req.op = OP_TICK;
            end
          end
          default: begin
            if (roll < 45) begin
              req.op     = OP_FINACK;
              req.ack_ok = 1'b1;
            end else if (roll < 75) begin
              req.op = OP_TICK;
            end
          end
        endcase
        issue_request(req, -1, NO_CMD);
        rand_cnt++;
        if (m_phase != PH_IDLE) started = 1'b1;
        phase_items++;
      end
    end

    // largest transfer last: it never drains, so nothing follows it
    settle();
    write_reg(TIMEOUT_ADDR, 32'd2);
    issue_request('{OP_START, 16'hFFFF, 8'd0, 1'b1}, -1, NO_CMD);
    issue_request('{OP_ACK, 16'd0, m_base[7:0] + 8'd1, 1'b1}, -1, NO_CMD);
    repeat (3) issue_request('{OP_TICK, 16'd0, 8'd0, 1'b0}, -1, NO_CMD);
    settle();

    if (mismatch_cnt == 0 && expected_cmds.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/gbn_pkg.sv
src/gbn_cmd_fifo.sv
src/gbn_front.sv
src/gbn_back.sv
src/go_back_n_sender_window.sv
tb/sv/testbench.sv
